FILE: sv/cpld_pkg.sv
// Shared types, constants and classification functions of the charge pilot level detector.
`default_nettype none

package cpld_pkg;

    localparam int GROUP_SIZE_LOG2_DEF = 3;

    localparam int SAMPLE_W = 12;
    localparam int WIN_W    = 8;
    localparam int SETTLE_W = 4;
    localparam int LEVEL_W  = 3;
    localparam int MV_W     = 12;
    localparam int CFG_W    = 8;

    localparam logic [WIN_W-1:0]    WINDOW_GROUPS_RST = 8'd20;
    localparam logic [SETTLE_W-1:0] SETTLE_GROUPS_RST = 4'd1;

    // Register indexes of the configuration port
    localparam logic CFG_WINDOW_GROUPS = 1'b0;
    localparam logic CFG_SETTLE_GROUPS = 1'b1;

    // peak * 806 / 1000 == (peak * MV_RECIP) >> MV_SHIFT for every 12-bit peak
    localparam int          MV_SHIFT = 32;
    localparam logic [31:0] MV_RECIP = 32'd3461743641;

    localparam logic [LEVEL_W-1:0] PILOT_FAULT = 3'd0;
    localparam logic [LEVEL_W-1:0] PILOT_3V    = 3'd1;
    localparam logic [LEVEL_W-1:0] PILOT_6V    = 3'd2;
    localparam logic [LEVEL_W-1:0] PILOT_9V    = 3'd3;
    localparam logic [LEVEL_W-1:0] PILOT_12V   = 3'd4;

    localparam logic [1:0] PROX_32A  = 2'd0;
    localparam logic [1:0] PROX_20A  = 2'd1;
    localparam logic [1:0] PROX_13A  = 2'd2;
    localparam logic [1:0] PROX_NONE = 2'd3;

    localparam logic [MV_W-1:0] PILOT_TH_3V   = 12'd352;
    localparam logic [MV_W-1:0] PILOT_TH_6V   = 12'd887;
    localparam logic [MV_W-1:0] PILOT_TH_9V   = 12'd1422;
    localparam logic [MV_W-1:0] PILOT_TH_12V  = 12'd2007;
    localparam logic [MV_W-1:0] PROX_TH_20A   = 12'd1129;
    localparam logic [MV_W-1:0] PROX_TH_13A   = 12'd1678;
    localparam logic [MV_W-1:0] PROX_TH_NONE  = 12'd2187;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                channel;
        logic                restart;
    } t_in_item;

    typedef struct packed {
        logic                valid;
        logic                channel;
        logic [SAMPLE_W-1:0] peak;
    } t_peak_evt;

    typedef struct packed {
        logic            valid;
        logic            channel;
        logic [MV_W-1:0] mv;
    } t_mv_evt;

    typedef struct packed {
        logic               result_channel;
        logic [LEVEL_W-1:0] level;
        logic               changed;
        logic [MV_W-1:0]    millivolts;
    } t_result;

    function automatic logic [LEVEL_W-1:0] pilot_class(input logic [MV_W-1:0] mv);
        logic [LEVEL_W-1:0] lvl;
        if (mv < PILOT_TH_3V) begin
            lvl = PILOT_FAULT;
        end else if (mv < PILOT_TH_6V) begin
            lvl = PILOT_3V;
        end else if (mv < PILOT_TH_9V) begin
            lvl = PILOT_6V;
        end else if (mv < PILOT_TH_12V) begin
            lvl = PILOT_9V;
        end else begin
            lvl = PILOT_12V;
        end
        return lvl;
    endfunction

    function automatic logic [1:0] prox_class(input logic [MV_W-1:0] mv);
        logic [1:0] lvl;
        if (mv < PROX_TH_20A) begin
            lvl = PROX_32A;
        end else if (mv < PROX_TH_13A) begin
            lvl = PROX_20A;
        end else if (mv < PROX_TH_NONE) begin
            lvl = PROX_13A;
        end else begin
            lvl = PROX_NONE;
        end
        return lvl;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cpld_window.sv
// Group averaging, settle discard and peak tracking over one measurement window.
`default_nettype none

module cpld_window
    import cpld_pkg::*;
#(
    parameter int GROUP_SIZE_LOG2 = GROUP_SIZE_LOG2_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic                i_in_valid,
    input  wire t_in_item            i_in,
    input  wire logic [WIN_W-1:0]    i_window_groups,
    input  wire logic [SETTLE_W-1:0] i_settle_groups,
    output t_peak_evt                o_evt
);

    localparam int SUM_W = SAMPLE_W + GROUP_SIZE_LOG2;
    localparam int CNT_W = GROUP_SIZE_LOG2 + 1;
    localparam logic [CNT_W-1:0] GRP_CNT = CNT_W'(1) << GROUP_SIZE_LOG2;

    logic [SUM_W-1:0]    r_sum,    n_sum;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;
    logic [WIN_W-1:0]    r_done,   n_done;
    logic [SETTLE_W-1:0] r_disc,   n_disc;
    logic [SAMPLE_W-1:0] r_peak,   n_peak;
    logic                r_active, n_active;
    t_peak_evt           r_evt,    n_evt;

    logic [SUM_W-1:0]    sum_b, sum_a;
    logic [CNT_W-1:0]    cnt_b, cnt_a;
    logic [WIN_W-1:0]    done_b, done_a, need;
    logic [SETTLE_W-1:0] disc_b;
    logic [SAMPLE_W-1:0] peak_b, peak_a, avg;
    logic                act_b;

    always_comb begin
        if (i_in.restart) begin
            sum_b  = '0;
            cnt_b  = '0;
            done_b = '0;
            disc_b = i_settle_groups;
            peak_b = '0;
            act_b  = 1'b1;
        end else begin
            sum_b  = r_sum;
            cnt_b  = r_cnt;
            done_b = r_done;
            disc_b = r_disc;
            peak_b = r_peak;
            act_b  = r_active;
        end

        sum_a  = sum_b + SUM_W'(i_in.sample);
        cnt_a  = cnt_b + CNT_W'(1);
        avg    = sum_a[GROUP_SIZE_LOG2 +: SAMPLE_W];
        peak_a = (avg > peak_b) ? avg : peak_b;
        done_a = done_b + WIN_W'(1);
        need   = (i_window_groups == '0) ? WIN_W'(1) : i_window_groups;

        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_done   = r_done;
        n_disc   = r_disc;
        n_peak   = r_peak;
        n_active = r_active;
        n_evt    = '0;
        n_evt.channel = i_in.channel;
        n_evt.peak    = peak_a;

        if (i_in_valid && act_b) begin
            n_done   = done_b;
            n_disc   = disc_b;
            n_peak   = peak_b;
            n_active = act_b;
            if (cnt_a != GRP_CNT) begin
                n_sum = sum_a;
                n_cnt = cnt_a;
            end else begin
                n_sum = '0;
                n_cnt = '0;
                if (disc_b != '0) begin
                    n_disc = disc_b - SETTLE_W'(1);
                end else begin
                    n_peak = peak_a;
                    n_done = done_a;
                    if (!(done_a < need)) begin
                        n_active    = 1'b0;
                        n_evt.valid = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_cnt     <= '0;
            r_done    <= '0;
            r_disc    <= '0;
            r_peak    <= '0;
            r_active  <= 1'b0;
            r_evt     <= '0;
        end else if (i_adv) begin
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_done    <= n_done;
            r_disc    <= n_disc;
            r_peak    <= n_peak;
            r_active  <= n_active;
            r_evt     <= n_evt;
        end
    end

    assign o_evt = r_evt;

    a_cnt_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < GRP_CNT)
        else $error("group count reached group size");

    a_close_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evt.valid |-> !r_active)
        else $error("window still active after close");

endmodule

`default_nettype wire

FILE: sv/cpld_scale.sv
// Peak to millivolt conversion by reciprocal multiplication.
`default_nettype none

module cpld_scale
    import cpld_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_adv,
    input  wire t_peak_evt i_evt,
    output t_mv_evt        o_evt
);

    localparam int PROD_W = SAMPLE_W + 32;

    logic [PROD_W-1:0] prod;
    logic              r_valid;
    logic              r_channel;
    logic [MV_W-1:0]   r_mv;

    assign prod = PROD_W'(i_evt.peak) * PROD_W'(MV_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_channel <= i_evt.channel;
            r_mv      <= prod[MV_SHIFT +: MV_W];
        end
    end

    assign o_evt = {r_valid, r_channel, r_mv};

endmodule

`default_nettype wire

FILE: sv/cpld_classify.sv
// Level classification, per-channel level tracking and the result register.
`default_nettype none

module cpld_classify
    import cpld_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_adv,
    input  wire t_mv_evt i_evt,
    output logic         o_valid,
    output t_result      o_result
);

    logic [LEVEL_W-1:0] r_pilot,  n_pilot;
    logic [1:0]         r_prox,   n_prox;
    logic               r_valid;
    t_result            r_result, n_result;
    logic [LEVEL_W-1:0] pilot_lvl;
    logic [1:0]         prox_lvl;

    always_comb begin
        pilot_lvl = pilot_class(i_evt.mv);
        prox_lvl  = prox_class(i_evt.mv);
        n_pilot   = r_pilot;
        n_prox    = r_prox;
        n_result.result_channel = i_evt.channel;
        n_result.millivolts     = i_evt.mv;
        if (!i_evt.channel) begin
            n_result.level   = pilot_lvl;
            n_result.changed = (pilot_lvl != r_pilot);
            if (i_evt.valid) begin
                n_pilot = pilot_lvl;
            end
        end else begin
            n_result.level   = LEVEL_W'(prox_lvl);
            n_result.changed = (prox_lvl != r_prox);
            if (i_evt.valid) begin
                n_prox = prox_lvl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pilot <= PILOT_12V;
            r_prox  <= PROX_NONE;
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_pilot <= n_pilot;
            r_prox  <= n_prox;
            r_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: sv/charge_pilot_level_detector_unit.sv
// Top level of the charge pilot level detector: ports, configuration and input register.
//
// Takes one ADC sample per cycle. After a restart it drops settle_groups groups of
// 2**GROUP_SIZE_LOG2 samples, then keeps the peak group average over window_groups
// groups and emits one item at window end: channel, pilot level or cable code, a
// changed flag and the peak in millivolts. Behind the input register, the result passes the
// window accumulator, the reciprocal multiplier, then the classifier and result register;
// all stages advance together, so the block takes one sample per cycle and stalls only
// while a result waits at the output.
`default_nettype none

module charge_pilot_level_detector_unit
    import cpld_pkg::*;
#(
    parameter int GROUP_SIZE_LOG2 = GROUP_SIZE_LOG2_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire logic [15:0]      i_s_axis_tdata,  // [11:0] sample
    input  wire logic [1:0]       i_s_axis_tuser,  // [0] channel, [1] restart
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,  // [2:0] level, [14:3] millivolts
    output logic [1:0]            o_m_axis_tuser,  // [0] result_channel, [1] changed
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    logic [WIN_W-1:0]    r_win;
    logic [SETTLE_W-1:0] r_settle;
    logic                adv;
    logic                r_in_valid;
    t_in_item            r_in;
    t_peak_evt           peak_evt;
    t_mv_evt             mv_evt;
    logic                res_valid;
    t_result             res;

    assign adv             = !res_valid || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= WINDOW_GROUPS_RST;
            r_settle <= SETTLE_GROUPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_GROUPS: r_win    <= i_cfg_data;
                CFG_SETTLE_GROUPS: r_settle <= i_cfg_data[SETTLE_W-1:0];
                default:           r_win    <= r_win;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in.sample  <= i_s_axis_tdata[SAMPLE_W-1:0];
            r_in.channel <= i_s_axis_tuser[0];
            r_in.restart <= i_s_axis_tuser[1];
        end
    end

    cpld_window #(
        .GROUP_SIZE_LOG2(GROUP_SIZE_LOG2)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_in_valid     (r_in_valid),
        .i_in           (r_in),
        .i_window_groups(r_win),
        .i_settle_groups(r_settle),
        .o_evt          (peak_evt)
    );

    cpld_scale u_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_evt  (peak_evt),
        .o_evt  (mv_evt)
    );

    cpld_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_evt   (mv_evt),
        .o_valid (res_valid),
        .o_result(res)
    );

    assign o_m_axis_tvalid = res_valid;
    assign o_m_axis_tdata  = {1'b0, res.millivolts, res.level};
    assign o_m_axis_tuser  = {res.changed, res.result_channel};

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while result stalled");

    a_cfg_settle_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == CFG_SETTLE_GROUPS)
        |=> (r_settle == $past(i_cfg_data[SETTLE_W-1:0])))
        else $error("settle register not written");

endmodule

`default_nettype wire
